// ===== hdl/snl_token_scanner_core_defines.svh =====
// Assertion macros for the token scanner. Each use names a label, an antecedent,
// a consequent and a message; clk and rst are taken from the enclosing module.
`ifndef SNL_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SNL_TOKEN_SCANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SNL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SNL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SNL_ASSERT_NOW(lbl, ante, cons, msg)
`define SNL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/snl_pkg.sv =====
package snl_pkg;

  localparam int KEYWORD_CHARS = 9;
  localparam int KEYWORD_COUNT = 21;
  localparam int LINE_BITS     = 16;
  localparam int POS_BITS      = 24;
  localparam int PFX_IDX_BITS  = $clog2(KEYWORD_CHARS);
  localparam int RQ_DEPTH      = 4;
  localparam int RQ_PTR_BITS   = $clog2(RQ_DEPTH);

  typedef logic [5:0] kind_t;
  typedef logic [2:0] err_t;

  localparam kind_t K_PROGRAM   = 6'd0;
  localparam kind_t K_TYPE      = 6'd1;
  localparam kind_t K_VAR       = 6'd2;
  localparam kind_t K_ENDFILE   = 6'd3;
  localparam kind_t K_ERROR     = 6'd4;
  localparam kind_t K_ID        = 6'd5;
  localparam kind_t K_INTC      = 6'd6;
  localparam kind_t K_CHARC     = 6'd7;
  localparam kind_t K_ASSIGN    = 6'd8;
  localparam kind_t K_PROCEDURE = 6'd9;
  localparam kind_t K_BEGIN     = 6'd10;
  localparam kind_t K_END       = 6'd11;
  localparam kind_t K_ARRAY     = 6'd12;
  localparam kind_t K_EQ        = 6'd13;
  localparam kind_t K_LT        = 6'd14;
  localparam kind_t K_PLUS      = 6'd15;
  localparam kind_t K_MINUS     = 6'd16;
  localparam kind_t K_TIMES     = 6'd17;
  localparam kind_t K_OVER      = 6'd18;
  localparam kind_t K_OF        = 6'd19;
  localparam kind_t K_RECORD    = 6'd20;
  localparam kind_t K_IF        = 6'd21;
  localparam kind_t K_THEN      = 6'd22;
  localparam kind_t K_ELSE      = 6'd23;
  localparam kind_t K_FI        = 6'd24;
  localparam kind_t K_LPAREN    = 6'd25;
  localparam kind_t K_RPAREN    = 6'd26;
  localparam kind_t K_DOT       = 6'd27;
  localparam kind_t K_SEMI      = 6'd29;
  localparam kind_t K_WHILE     = 6'd30;
  localparam kind_t K_DO        = 6'd31;
  localparam kind_t K_ENDWH     = 6'd32;
  localparam kind_t K_READ      = 6'd33;
  localparam kind_t K_WRITE     = 6'd34;
  localparam kind_t K_COMMA     = 6'd35;
  localparam kind_t K_LMIDPAREN = 6'd36;
  localparam kind_t K_RMIDPAREN = 6'd37;
  localparam kind_t K_UNDERANGE = 6'd38;
  localparam kind_t K_RETURN    = 6'd39;
  localparam kind_t K_INTEGER   = 6'd40;
  localparam kind_t K_CHAR      = 6'd41;
  localparam kind_t K_GT        = 6'd42;

  localparam err_t E_NONE       = 3'd0;
  localparam err_t E_BAD_CHAR   = 3'd1;
  localparam err_t E_BAD_ASSIGN = 3'd2;
  localparam err_t E_BAD_NUMBER = 3'd3;
  localparam err_t E_BAD_BODY   = 3'd4;
  localparam err_t E_OPEN_LIT   = 3'd5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keywords are space padded to KEYWORD_CHARS; character i sits in byte i from the top.
  localparam logic [8*KEYWORD_CHARS-1:0] KW_TEXT [KEYWORD_COUNT] = '{
    "program  ", "type     ", "var      ", "procedure", "begin    ", "end      ",
    "array    ", "of       ", "record   ", "if       ", "then     ", "else     ",
    "fi       ", "while    ", "do       ", "endwh    ", "read     ", "write    ",
    "return   ", "integer  ", "char     "
  };
  localparam logic [7:0] KW_LEN [KEYWORD_COUNT] = '{
    8'd7, 8'd4, 8'd3, 8'd9, 8'd5, 8'd3, 8'd5, 8'd2, 8'd6, 8'd2, 8'd4,
    8'd4, 8'd2, 8'd5, 8'd2, 8'd5, 8'd4, 8'd5, 8'd6, 8'd7, 8'd4
  };
  localparam kind_t KW_CODE [KEYWORD_COUNT] = '{
    K_PROGRAM, K_TYPE, K_VAR, K_PROCEDURE, K_BEGIN, K_END, K_ARRAY, K_OF,
    K_RECORD, K_IF, K_THEN, K_ELSE, K_FI, K_WHILE, K_DO, K_ENDWH, K_READ,
    K_WRITE, K_RETURN, K_INTEGER, K_CHAR
  };

  typedef enum logic [9:0] {
    M_START   = 10'b00_0000_0001,
    M_ID      = 10'b00_0000_0010,
    M_NUM     = 10'b00_0000_0100,
    M_BADNUM  = 10'b00_0000_1000,
    M_COLON   = 10'b00_0001_0000,
    M_DOT     = 10'b00_0010_0000,
    M_COMMENT = 10'b00_0100_0000,
    M_QUOTE   = 10'b00_1000_0000,
    M_BODY    = 10'b01_0000_0000,
    M_SKIP    = 10'b10_0000_0000
  } mode_t;

  typedef logic [KEYWORD_CHARS-1:0][7:0] prefix_t;

  typedef struct packed {
    mode_t                mode;
    logic [LINE_BITS-1:0] line_count;
    logic [POS_BITS-1:0]  byte_pos;
    logic [POS_BITS-1:0]  token_start;
    logic [7:0]           token_len;
    logic [15:0]          number_value;
    logic                 halted;
  } scan_state_t;

  typedef struct packed {
    kind_t       kind;
    err_t        err;
    logic [15:0] line;
    logic [23:0] start;
    logic [7:0]  len;
    logic [15:0] value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic                    we;
    logic [PFX_IDX_BITS-1:0] idx;
    logic [7:0]              data;
  } pfx_wr_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } delim_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic delim_t delim_kind(logic [7:0] c);
    delim_t d;
    d.hit = 1'b1;
    case (c)
      "+":     d.kind = K_PLUS;
      "-":     d.kind = K_MINUS;
      "*":     d.kind = K_TIMES;
      "/":     d.kind = K_OVER;
      "(":     d.kind = K_LPAREN;
      ")":     d.kind = K_RPAREN;
      ";":     d.kind = K_SEMI;
      "[":     d.kind = K_LMIDPAREN;
      "]":     d.kind = K_RMIDPAREN;
      "=":     d.kind = K_EQ;
      "<":     d.kind = K_LT;
      ">":     d.kind = K_GT;
      ",":     d.kind = K_COMMA;
      default: begin
        d.hit  = 1'b0;
        d.kind = K_ERROR;
      end
    endcase
    return d;
  endfunction

  // Words longer than KEYWORD_CHARS cannot match any length entry and fall out as ID.
  function automatic kind_t word_kind(prefix_t p, logic [7:0] len);
    kind_t kind;
    logic  hit;
    kind = K_ID;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      hit = (len == KW_LEN[k]);
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        if (i < int'(KW_LEN[k]) && p[i] != KW_TEXT[k][8*(KEYWORD_CHARS-1-i) +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) kind = KW_CODE[k];
    end
    return kind;
  endfunction

  function automatic result_t make_result(kind_t kind, err_t err, logic [LINE_BITS-1:0] line,
                                          logic [POS_BITS-1:0] start, logic [7:0] len,
                                          logic [15:0] value);
    result_t r;
    r.kind  = kind;
    r.err   = err;
    r.line  = 16'(line);
    r.start = 24'(start);
    r.len   = len;
    r.value = value;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

// ===== hdl/snl_step.sv =====
module snl_step (
  input  snl_pkg::scan_state_t st,
  input  snl_pkg::prefix_t     prefix,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_input,
  output snl_pkg::scan_state_t st_next,
  output snl_pkg::pfx_wr_t     pfx_wr,
  output snl_pkg::result_t     res0,
  output snl_pkg::result_t     res1,
  output logic [1:0]           res_count
);
  import snl_pkg::*;

  logic [7:0]          c;
  logic                eof;
  logic [POS_BITS-1:0] pos;
  logic [19:0]         num_prod;
  delim_t              dl;
  result_t             ra;
  result_t             rb;
  logic                va;
  logic                vb;
  logic                redo;
  logic                grow_en;

  assign c        = in_byte;
  assign eof      = end_of_input;
  assign pos      = st.byte_pos;
  assign num_prod = 20'(st.number_value) * 20'd10 + 20'(c[3:0]);
  assign dl       = delim_kind(c);

  always_comb begin
    st_next = st;
    pfx_wr  = '0;
    ra      = '0;
    rb      = '0;
    va      = 1'b0;
    vb      = 1'b0;
    redo    = 1'b0;
    grow_en = 1'b0;

    if (!st.halted) begin
      if (!eof) st_next.byte_pos = pos + POS_BITS'(1);

      // First phase: the pending token, if any, is finished or extended.
      case (st.mode)
        M_ID: begin
          if (!eof && is_alnum(c)) begin
            grow_en = 1'b1;
          end else begin
            ra   = make_result(word_kind(prefix, st.token_len), E_NONE, st.line_count,
                               st.token_start, st.token_len, 16'd0);
            va   = 1'b1;
            redo = 1'b1;
          end
        end
        M_NUM: begin
          if (!eof && is_digit(c)) begin
            st_next.number_value = (num_prod > 20'hFFFF) ? 16'hFFFF : num_prod[15:0];
            grow_en = 1'b1;
          end else if (!eof && is_alpha(c)) begin
            grow_en      = 1'b1;
            st_next.mode = M_BADNUM;
          end else begin
            ra   = make_result(K_INTC, E_NONE, st.line_count, st.token_start,
                               st.token_len, st.number_value);
            va   = 1'b1;
            redo = 1'b1;
          end
        end
        M_BADNUM: begin
          if (!eof && is_alnum(c)) begin
            grow_en = 1'b1;
          end else begin
            ra   = make_result(K_ERROR, E_BAD_NUMBER, st.line_count, st.token_start,
                               st.token_len, 16'd0);
            va   = 1'b1;
            redo = 1'b1;
          end
        end
        M_COLON: begin
          va = 1'b1;
          if (!eof && c == CH_EQUAL) begin
            ra           = make_result(K_ASSIGN, E_NONE, st.line_count, st.token_start,
                                       8'd2, 16'd0);
            st_next.mode = M_START;
          end else begin
            ra             = make_result(K_ERROR, E_BAD_ASSIGN, st.line_count,
                                         st.token_start, 8'd1, 16'd0);
            st_next.halted = 1'b1;
          end
        end
        M_DOT: begin
          va = 1'b1;
          if (!eof && c == CH_DOT) begin
            ra           = make_result(K_UNDERANGE, E_NONE, st.line_count, st.token_start,
                                       8'd2, 16'd0);
            st_next.mode = M_START;
          end else begin
            ra   = make_result(K_DOT, E_NONE, st.line_count, st.token_start, 8'd1, 16'd0);
            redo = 1'b1;
          end
        end
        M_COMMENT: begin
          if (eof) redo = 1'b1;
          else if (c == CH_RBRACE) st_next.mode = M_START;
        end
        M_QUOTE: begin
          va = 1'b1;
          if (!eof && is_alnum(c)) begin
            ra           = make_result(K_CHARC, E_NONE, st.line_count, pos, 8'd1,
                                       {8'd0, c});
            st_next.mode = M_BODY;
          end else begin
            ra             = make_result(K_ERROR, E_BAD_BODY, st.line_count,
                                         st.token_start, 8'd1, 16'd0);
            st_next.halted = 1'b1;
          end
        end
        M_BODY: begin
          if (!eof && c == CH_QUOTE) begin
            st_next.mode = M_START;
          end else begin
            ra = make_result(K_ERROR, E_OPEN_LIT, st.line_count, st.token_start,
                             8'd2, 16'd0);
            va = 1'b1;
            if (eof) redo = 1'b1;
            else st_next.mode = M_SKIP;
          end
        end
        M_SKIP: begin
          if (eof) redo = 1'b1;
          else if (c == CH_QUOTE) st_next.mode = M_START;
        end
        default: begin
          redo = 1'b1;
        end
      endcase

      if (grow_en) begin
        if (st.token_len < 8'(KEYWORD_CHARS)) begin
          pfx_wr.we   = 1'b1;
          pfx_wr.idx  = st.token_len[PFX_IDX_BITS-1:0];
          pfx_wr.data = c;
        end
        if (st.token_len != 8'hFF) st_next.token_len = st.token_len + 8'd1;
      end

      // Second phase: when redo is set, the byte is scanned again from the start state.
      if (redo) begin
        st_next.mode = M_START;
        if (eof) begin
          rb = make_result(K_ENDFILE, E_NONE, st.line_count, pos, 8'd0, 16'd0);
          vb = 1'b1;
        end else if (c == CH_NL) begin
          if (st.line_count != '1) st_next.line_count = st.line_count + LINE_BITS'(1);
        end else if (is_alpha(c) || is_digit(c)) begin
          st_next.token_start = pos;
          st_next.token_len   = 8'd1;
          pfx_wr.we           = 1'b1;
          pfx_wr.idx          = '0;
          pfx_wr.data         = c;
          if (is_alpha(c)) begin
            st_next.mode = M_ID;
          end else begin
            st_next.number_value = {12'd0, c[3:0]};
            st_next.mode         = M_NUM;
          end
        end else if (c == CH_LBRACE) begin
          st_next.mode = M_COMMENT;
        end else if (c == CH_COLON) begin
          st_next.token_start = pos;
          st_next.mode        = M_COLON;
        end else if (c == CH_DOT) begin
          st_next.token_start = pos;
          st_next.mode        = M_DOT;
        end else if (c == CH_QUOTE) begin
          st_next.token_start = pos;
          st_next.mode        = M_QUOTE;
        end else if (dl.hit) begin
          rb = make_result(dl.kind, E_NONE, st.line_count, pos, 8'd1, 16'd0);
          vb = 1'b1;
        end else if (!(c == CH_SPACE || c == CH_TAB)) begin
          rb = make_result(K_ERROR, E_BAD_CHAR, st.line_count, pos, 8'd1, {8'd0, c});
          vb = 1'b1;
        end
      end
    end

    res0      = va ? ra : rb;
    res0.last = !(va && vb);
    res1      = rb;
    res1.last = 1'b1;
    res_count = {1'b0, va} + {1'b0, vb};
  end

endmodule

// ===== hdl/snl_token_scanner_core.sv =====
// Each result is written into the result queue at the edge that accepts its byte.
// Throughput: one source byte per cycle; a byte that completes two tokens fills two
// slots of the four-entry result queue, and input stalls while three or more wait.
// Reset (rst, synchronous, active high) restores the start state, line 1, position 0,
// and empties the queue; the stored word characters are not cleared.
`include "snl_token_scanner_core_defines.svh"

module snl_token_scanner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_kind,
  output logic [2:0]  error_code,
  output logic [15:0] line_number,
  output logic [23:0] start_pos,
  output logic [7:0]  lexeme_length,
  output logic [15:0] lexeme_value,
  output logic        is_last
);
  import snl_pkg::*;

  scan_state_t            st;
  scan_state_t            st_next;
  prefix_t                prefix;
  pfx_wr_t                pfx_wr;
  result_t                res0;
  result_t                res1;
  logic [1:0]             res_count;
  logic                   in_accept;
  logic                   out_pop;
  logic [1:0]             push_count;
  result_t                queue [RQ_DEPTH];
  result_t                head;
  logic [RQ_PTR_BITS-1:0] wr_ptr;
  logic [RQ_PTR_BITS-1:0] wr_ptr_inc;
  logic [RQ_PTR_BITS-1:0] rd_ptr;
  logic [RQ_PTR_BITS:0]   count;
  logic [RQ_PTR_BITS:0]   count_next;

  snl_step u_step (
    .st           (st),
    .prefix       (prefix),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .st_next      (st_next),
    .pfx_wr       (pfx_wr),
    .res0         (res0),
    .res1         (res1),
    .res_count    (res_count)
  );

  // Room for two results is kept free so any byte can be taken.
  assign in_ready   = count <= (RQ_PTR_BITS+1)'(RQ_DEPTH - 2);
  assign in_accept  = in_valid && in_ready;
  assign out_valid  = count != '0;
  assign out_pop    = out_valid && out_ready;
  assign push_count = in_accept ? res_count : 2'd0;
  assign wr_ptr_inc = wr_ptr + RQ_PTR_BITS'(1);
  assign count_next = count + (RQ_PTR_BITS+1)'(push_count)
                    - (RQ_PTR_BITS+1)'(out_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode         <= M_START;
      st.line_count   <= LINE_BITS'(1);
      st.byte_pos     <= '0;
      st.token_start  <= '0;
      st.token_len    <= '0;
      st.number_value <= '0;
      st.halted       <= 1'b0;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && pfx_wr.we) prefix[pfx_wr.idx] <= pfx_wr.data;
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) queue[wr_ptr] <= res0;
    if (push_count == 2'd2) queue[wr_ptr_inc] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PTR_BITS'(push_count);
      if (out_pop) rd_ptr <= rd_ptr + RQ_PTR_BITS'(1);
      count <= count_next;
    end
  end

  assign head          = queue[rd_ptr];
  assign token_kind    = head.kind;
  assign error_code    = head.err;
  assign line_number   = head.line;
  assign start_pos     = head.start;
  assign lexeme_length = head.len;
  assign lexeme_value  = head.value;
  assign is_last       = head.last;

  `SNL_ASSERT_NOW(a_queue_bound, 1'b1, count <= (RQ_PTR_BITS+1)'(RQ_DEPTH), "result queue overflow")
  `SNL_ASSERT_NOW(a_halted_silent, in_accept && st.halted, res_count == 2'd0, "result while halted")
  `SNL_ASSERT_NEXT(a_halt_sticky, st.halted, st.halted, "halt released without reset")
  `SNL_ASSERT_NOW(a_pair_order, in_accept && res_count == 2'd2, !res0.last && res1.last, "pair order")

endmodule

// ===== test/tb_snl_token_scanner_core.sv =====
`timescale 1ns / 100ps

module tb_snl_token_scanner_core;
  import snl_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  token_kind;
  logic [2:0]  error_code;
  logic [15:0] line_number;
  logic [23:0] start_pos;
  logic [7:0]  lexeme_length;
  logic [15:0] lexeme_value;
  logic        is_last;

  snl_token_scanner_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_input  (end_of_input),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_kind    (token_kind),
    .error_code    (error_code),
    .line_number   (line_number),
    .start_pos     (start_pos),
    .lexeme_length (lexeme_length),
    .lexeme_value  (lexeme_value),
    .is_last       (is_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scanner state as the source text should leave it.
  mode_t       cur_mode;
  logic [15:0] line_no;
  logic [23:0] src_pos;
  logic [23:0] lex_start;
  logic [7:0]  lex_len;
  string       lex_word;
  logic [15:0] int_value;
  logic        scan_halted;

  result_t step_tokens [$];
  result_t token_fifo [$];

  string kw_words [KEYWORD_COUNT] = '{
    "program", "type", "var", "procedure", "begin", "end", "array", "of", "record",
    "if", "then", "else", "fi", "while", "do", "endwh", "read", "write", "return",
    "integer", "char"
  };
  kind_t kw_kinds [KEYWORD_COUNT] = '{
    K_PROGRAM, K_TYPE, K_VAR, K_PROCEDURE, K_BEGIN, K_END, K_ARRAY, K_OF, K_RECORD,
    K_IF, K_THEN, K_ELSE, K_FI, K_WHILE, K_DO, K_ENDWH, K_READ, K_WRITE, K_RETURN,
    K_INTEGER, K_CHAR
  };
  string delim_chars = "+-*/();[]=<>,";

  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          kw_turn = 0;
  int          bytes_fed = 0;
  int          tokens_checked = 0;
  int          errors_seen = 0;
  string       fatal_case = "";

  function automatic logic alpha_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alnum_char(logic [7:0] c);
    return alpha_char(c) || digit_char(c);
  endfunction

  function automatic logic [7:0] rand_alpha();
    int unsigned r;
    r = $urandom_range(51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(4) == 0) ? rand_digit() : rand_alpha();
  endfunction

  function automatic kind_t keyword_code();
    if (lex_len > KEYWORD_CHARS) return K_ID;
    foreach (kw_words[k]) begin
      if (kw_words[k] == lex_word) return kw_kinds[k];
    end
    return K_ID;
  endfunction

  task automatic add_token(kind_t k, err_t e, logic [23:0] s, logic [7:0] n,
                           logic [15:0] v);
    result_t t;
    t.kind  = k;
    t.err   = e;
    t.line  = line_no;
    t.start = s;
    t.len   = n;
    t.value = v;
    t.last  = 1'b0;
    if (step_tokens.size() < 2) step_tokens.push_back(t);
  endtask

  task automatic reset_scanner_state();
    cur_mode    = M_START;
    line_no     = 16'd1;
    src_pos     = '0;
    lex_start   = '0;
    lex_len     = '0;
    lex_word    = "";
    int_value   = '0;
    scan_halted = 1'b0;
    token_fifo.delete();
  endtask

  task automatic open_word(logic [7:0] c, logic [23:0] pos);
    lex_start = pos;
    lex_len   = 8'd1;
    lex_word  = $sformatf("%c", c);
  endtask

  task automatic grow_word(logic [7:0] c);
    if (lex_len < KEYWORD_CHARS) lex_word = $sformatf("%s%c", lex_word, c);
    if (lex_len != 8'hFF) lex_len++;
  endtask

  // Handles a byte seen from the start state.
  task automatic start_scan(logic [7:0] c, logic [23:0] pos);
    cur_mode = M_START;
    if (c == CH_NL) begin
      if (line_no != 16'hFFFF) line_no++;
    end else if (alpha_char(c)) begin
      open_word(c, pos);
      cur_mode = M_ID;
    end else if (digit_char(c)) begin
      open_word(c, pos);
      int_value = 16'(c - "0");
      cur_mode  = M_NUM;
    end else if (c == CH_LBRACE) begin
      cur_mode = M_COMMENT;
    end else if (c == CH_COLON) begin
      lex_start = pos;
      cur_mode  = M_COLON;
    end else if (c == CH_DOT) begin
      lex_start = pos;
      cur_mode  = M_DOT;
    end else if (c == CH_QUOTE) begin
      lex_start = pos;
      cur_mode  = M_QUOTE;
    end else begin
      case (c)
        "+": add_token(K_PLUS, E_NONE, pos, 8'd1, 16'd0);
        "-": add_token(K_MINUS, E_NONE, pos, 8'd1, 16'd0);
        "*": add_token(K_TIMES, E_NONE, pos, 8'd1, 16'd0);
        "/": add_token(K_OVER, E_NONE, pos, 8'd1, 16'd0);
        "(": add_token(K_LPAREN, E_NONE, pos, 8'd1, 16'd0);
        ")": add_token(K_RPAREN, E_NONE, pos, 8'd1, 16'd0);
        ";": add_token(K_SEMI, E_NONE, pos, 8'd1, 16'd0);
        "[": add_token(K_LMIDPAREN, E_NONE, pos, 8'd1, 16'd0);
        "]": add_token(K_RMIDPAREN, E_NONE, pos, 8'd1, 16'd0);
        "=": add_token(K_EQ, E_NONE, pos, 8'd1, 16'd0);
        "<": add_token(K_LT, E_NONE, pos, 8'd1, 16'd0);
        ">": add_token(K_GT, E_NONE, pos, 8'd1, 16'd0);
        ",": add_token(K_COMMA, E_NONE, pos, 8'd1, 16'd0);
        CH_SPACE, CH_TAB: ;
        default: add_token(K_ERROR, E_BAD_CHAR, pos, 8'd1, {8'h00, c});
      endcase
    end
  endtask

  // Advances the scanner by one byte and queues the tokens it completes.
  task automatic predict_scan(logic [7:0] c, logic eof);
    logic [23:0] pos;
    logic        redo;
    logic [31:0] v;
    step_tokens.delete();
    if (scan_halted) return;
    pos  = src_pos;
    redo = 1'b0;
    if (!eof) src_pos = src_pos + 24'd1;
    case (cur_mode)
      M_ID: begin
        if (!eof && alnum_char(c)) grow_word(c);
        else begin
          add_token(keyword_code(), E_NONE, lex_start, lex_len, 16'd0);
          redo = 1'b1;
        end
      end
      M_NUM: begin
        if (!eof && digit_char(c)) begin
          v = {16'h0, int_value} * 32'd10 + {24'h0, c} - 32'h30;
          int_value = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
          grow_word(c);
        end else if (!eof && alpha_char(c)) begin
          grow_word(c);
          cur_mode = M_BADNUM;
        end else begin
          add_token(K_INTC, E_NONE, lex_start, lex_len, int_value);
          redo = 1'b1;
        end
      end
      M_BADNUM: begin
        if (!eof && alnum_char(c)) grow_word(c);
        else begin
          add_token(K_ERROR, E_BAD_NUMBER, lex_start, lex_len, 16'd0);
          redo = 1'b1;
        end
      end
      M_COLON: begin
        if (!eof && c == CH_EQUAL) begin
          add_token(K_ASSIGN, E_NONE, lex_start, 8'd2, 16'd0);
          cur_mode = M_START;
        end else begin
          add_token(K_ERROR, E_BAD_ASSIGN, lex_start, 8'd1, 16'd0);
          scan_halted = 1'b1;
        end
      end
      M_DOT: begin
        if (!eof && c == CH_DOT) begin
          add_token(K_UNDERANGE, E_NONE, lex_start, 8'd2, 16'd0);
          cur_mode = M_START;
        end else begin
          add_token(K_DOT, E_NONE, lex_start, 8'd1, 16'd0);
          redo = 1'b1;
        end
      end
      M_COMMENT: begin
        if (eof) redo = 1'b1;
        else if (c == CH_RBRACE) cur_mode = M_START;
      end
      M_QUOTE: begin
        if (!eof && alnum_char(c)) begin
          add_token(K_CHARC, E_NONE, pos, 8'd1, {8'h00, c});
          cur_mode = M_BODY;
        end else begin
          add_token(K_ERROR, E_BAD_BODY, lex_start, 8'd1, 16'd0);
          scan_halted = 1'b1;
        end
      end
      M_BODY: begin
        if (!eof && c == CH_QUOTE) cur_mode = M_START;
        else begin
          add_token(K_ERROR, E_OPEN_LIT, lex_start, 8'd2, 16'd0);
          if (eof) redo = 1'b1;
          else cur_mode = M_SKIP;
        end
      end
      M_SKIP: begin
        if (eof) redo = 1'b1;
        else if (c == CH_QUOTE) cur_mode = M_START;
      end
      default: redo = 1'b1;
    endcase
    if (redo) begin
      if (eof) begin
        add_token(K_ENDFILE, E_NONE, pos, 8'd0, 16'd0);
        cur_mode = M_START;
      end else begin
        start_scan(c, pos);
      end
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) token_fifo.push_back(step_tokens[i]);
  endtask

  // Offers one byte and returns right after the edge that takes the transaction.
  task automatic feed(logic [7:0] c, logic eof);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= c;
    end_of_input <= eof;
    predict_scan(c, eof);
    bytes_fed++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Steers away from the two fatal errors so that random traffic keeps scanning.
  task automatic feed_safe(logic [7:0] c, logic eof);
    if (!scan_halted && cur_mode == M_COLON) begin
      c   = CH_EQUAL;
      eof = 1'b0;
    end else if (!scan_halted && cur_mode == M_QUOTE) begin
      c   = rand_alnum();
      eof = 1'b0;
    end
    feed(c, eof);
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) feed_safe(s[i], 1'b0);
  endtask

  task automatic gen_token();
    int unsigned r;
    string       s;
    r = $urandom_range(99);
    if (r < 22) begin
      s = kw_words[kw_turn % KEYWORD_COUNT];
      kw_turn++;
      case ($urandom_range(5))
        0: s = $sformatf("%s%c", s, rand_alnum());
        1: s = s.toupper();
        default: ;
      endcase
      feed_text(s);
    end else if (r < 40) begin
      feed_safe(rand_alpha(), 1'b0);
      repeat ($urandom_range(11)) feed_safe(rand_alnum(), 1'b0);
    end else if (r < 52) begin
      repeat ($urandom_range(6, 1)) feed_safe(rand_digit(), 1'b0);
      if ($urandom_range(5) == 0) begin
        feed_safe(rand_alpha(), 1'b0);
        repeat ($urandom_range(3)) feed_safe(rand_alnum(), 1'b0);
      end
    end else if (r < 68) begin
      feed_safe(delim_chars[$urandom_range(12)], 1'b0);
    end else if (r < 73) begin
      feed_text(":=");
    end else if (r < 78) begin
      if ($urandom_range(1) == 0) feed_text("..");
      else feed_safe(CH_DOT, 1'b0);
    end else if (r < 84) begin
      feed_safe(CH_QUOTE, 1'b0);
      feed_safe(rand_alnum(), 1'b0);
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(3, 1)) feed_safe(($urandom_range(1) == 0) ? CH_SPACE
                                                : rand_alnum(), 1'b0);
      end
      feed_safe(CH_QUOTE, 1'b0);
    end else if (r < 89) begin
      feed_safe(CH_LBRACE, 1'b0);
      repeat ($urandom_range(8)) begin
        s = $sformatf("%c", 8'($urandom_range(126, 32)));
        feed_safe((s[0] == CH_RBRACE) ? CH_NL : s[0], 1'b0);
      end
      feed_safe(CH_RBRACE, 1'b0);
    end else if (r < 93) begin
      feed_safe(8'($urandom_range(255)), 1'b0);
    end else if (r < 95) begin
      feed_safe(8'($urandom_range(255)), 1'b1);
    end else begin
      feed_safe(CH_NL, 1'b0);
    end
    case ($urandom_range(9))
      0, 1, 2, 3: feed_safe(CH_SPACE, 1'b0);
      4: feed_safe(CH_TAB, 1'b0);
      5: feed_safe(CH_NL, 1'b0);
      default: ;
    endcase
  endtask

  task automatic set_idle(int src_pct, int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
  endtask

  task automatic test_directed_specials();
    // Saturating number, number running into a letter, literal left open, newline
    // inside a comment, a range, a dot cut short by a lone closing brace.
    feed_text("x:=99999 7z'ax'{\n}...}");
    feed(8'hFF, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h5A, 1'b1);
    feed(CH_LBRACE, 1'b0);
    feed(8'hA5, 1'b1);
  endtask

  task automatic test_random_traffic(int n);
    int target;
    target = bytes_fed + n;
    while (bytes_fed < target) gen_token();
  endtask

  task automatic test_long_lexeme();
    feed_safe(CH_SPACE, 1'b0);
    feed_safe(rand_alpha(), 1'b0);
    repeat ($urandom_range(265, 250)) feed_safe(rand_alnum(), 1'b0);
    feed_safe(CH_SPACE, 1'b0);
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    hold_req <= hold_req + 1;
    // Each word ends on a delimiter, so many bytes bring two results at once.
    repeat (40) begin
      feed_safe(rand_alpha(), 1'b0);
      feed_safe(delim_chars[$urandom_range(12)], 1'b0);
    end
  endtask

  task automatic test_fatal_error();
    feed_safe(8'($urandom_range(255)), 1'b1);
    case ($urandom_range(3))
      0: begin fatal_case = "assign"; feed(CH_COLON, 1'b0); feed(8'h78, 1'b0); end
      1: begin fatal_case = "assign"; feed(CH_COLON, 1'b0); feed(8'h00, 1'b1); end
      2: begin fatal_case = "literal"; feed(CH_QUOTE, 1'b0); feed(CH_SPACE, 1'b0); end
      default: begin fatal_case = "literal"; feed(CH_QUOTE, 1'b0); feed(8'hFF, 1'b1); end
    endcase
    // Once halted the scanner must stay silent.
    repeat (6) feed(8'($urandom_range(255)), 1'b0);
    feed(8'h00, 1'b1);
  endtask

  task automatic check_token();
    result_t want;
    if (token_fifo.size() == 0) begin
      $error("token with nothing expected: kind %0d at %0d", token_kind, start_pos);
      errors_seen++;
    end else begin
      want = token_fifo.pop_front();
      tokens_checked++;
      if (token_kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
        errors_seen++;
      end
      if (error_code !== want.err) begin
        $error("error_code: expected %0d, got %0d", want.err, error_code);
        errors_seen++;
      end
      if (line_number !== want.line) begin
        $error("line_number: expected %0d, got %0d", want.line, line_number);
        errors_seen++;
      end
      if (start_pos !== want.start) begin
        $error("start_pos: expected %0d, got %0d", want.start, start_pos);
        errors_seen++;
      end
      if (lexeme_length !== want.len) begin
        $error("lexeme_length: expected %0d, got %0d", want.len, lexeme_length);
        errors_seen++;
      end
      if (lexeme_value !== want.value) begin
        $error("lexeme_value: expected %0d, got %0d", want.value, lexeme_value);
        errors_seen++;
      end
      if (is_last !== want.last) begin
        $error("is_last: expected %0d, got %0d", want.last, is_last);
        errors_seen++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_token();
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    reset_scanner_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_idle(10, 48);
    test_directed_specials();
    test_random_traffic(80);
    set_idle(48, 10);
    test_random_traffic(80);
    test_long_lexeme();
    set_idle(0, 0);
    test_random_traffic(80);
    test_backpressure();
    test_fatal_error();

    in_valid <= 1'b0;
    while (token_fifo.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Scanned %0d source bytes and checked %0d tokens under three idle mixes,",
             bytes_fed, tokens_checked);
    $display("with a %0d-cycle output stall and a closing fatal %s error.",
             HOLD_CYCLES, fatal_case);
    if (errors_seen == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/snl_pkg.sv
hdl/snl_step.sv
hdl/snl_token_scanner_core.sv
test/tb_snl_token_scanner_core.sv
